// ----- rtl/gb3_pkg.sv -----
// Shared types and constants of the gaborish 3x3 row filter.
// Used by gb3_ctrl, gb3_datapath and gaborish_3x3_row_filter; depends on nothing.
package gb3_pkg;

    localparam int SAMPLE_BITS = 20;
    localparam int WEIGHT_BITS = 16;
    localparam int GAIN_BITS   = 17;
    localparam int CFG_BITS    = 17;
    localparam int IDX_BITS    = 2;

    localparam logic [IDX_BITS-1:0] REG_SIDE_WEIGHT = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_DIAG_WEIGHT = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_NORM_GAIN   = 2'd2;

    localparam logic [WEIGHT_BITS-1:0] SIDE_WEIGHT_RST = 16'd7548;
    localparam logic [WEIGHT_BITS-1:0] DIAG_WEIGHT_RST = 16'd4014;
    localparam logic [GAIN_BITS-1:0]   NORM_GAIN_RST   = 17'd38423;

    // datapath widths
    localparam int SUM_BITS  = SAMPLE_BITS + 2;
    localparam int PROD_BITS = SUM_BITS + WEIGHT_BITS + 1;
    localparam int ACC_BITS  = SAMPLE_BITS + 20;
    localparam int HI_BITS   = ACC_BITS - 16;
    localparam int HG_BITS   = HI_BITS + GAIN_BITS + 1;
    localparam int LG_BITS   = 16 + GAIN_BITS;
    localparam int RND_BITS  = HG_BITS + 1;
    localparam int Y_BITS    = RND_BITS - 16;

    // length of a result pass: from stable operands to a result at the last pipeline register
    localparam int CALC_STEPS = 4;
    localparam int CNT_BITS   = 2;

    // left column select
    localparam logic [1:0] LSEL_OLD  = 2'd0;
    localparam logic [1:0] LSEL_PREV = 2'd1;
    localparam logic [1:0] LSEL_CUR  = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] t;
        logic signed [SAMPLE_BITS-1:0] c;
        logic signed [SAMPLE_BITS-1:0] b;
    } t_column;

    typedef struct packed {
        logic       load_cur;
        logic       win_from_in;
        logic       win_from_cur;
        logic [1:0] lsel;
        logic       mid_cur;
        logic       out_load;
        logic       out_end;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// ----- rtl/gb3_ctrl.sv -----
// Sequencer of the gaborish row filter: row position, result passes, output loads.
// Depends on gb3_pkg; drives gb3_datapath through t_dp_cmd.
module gb3_ctrl import gb3_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_last_column,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_PUT  = 2'd2;

    localparam logic [1:0] MODE_MID = 2'd0;
    localparam logic [1:0] MODE_END = 2'd1;
    localparam logic [1:0] MODE_ONE = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [1:0]          r_mode, n_mode;
    logic [1:0]          r_held, n_held;
    logic                r_last, n_last;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_held  = r_held;
        n_last  = r_last;
        n_cnt   = r_cnt;
        o_cmd   = '0;

        case (r_mode)
            MODE_MID: begin
                o_cmd.lsel    = (r_held == 2'd2) ? LSEL_OLD : LSEL_PREV;
                o_cmd.mid_cur = 1'b0;
            end
            MODE_END: begin
                o_cmd.lsel    = LSEL_PREV;
                o_cmd.mid_cur = 1'b1;
            end
            default: begin
                o_cmd.lsel    = LSEL_CUR;
                o_cmd.mid_cur = 1'b1;
            end
        endcase
        o_cmd.out_end = (r_mode != MODE_MID);

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_last = i_last_column;
                    n_cnt  = '0;
                    if (r_held == 2'd0 && !i_last_column) begin
                        o_cmd.win_from_in = 1'b1;
                        n_held            = 2'd1;
                    end else begin
                        o_cmd.load_cur = 1'b1;
                        n_mode         = (r_held == 2'd0) ? MODE_ONE : MODE_MID;
                        n_state        = S_CALC;
                    end
                end
            end
            S_CALC: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(CALC_STEPS - 1)) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_cnt          = '0;
                    if (r_mode == MODE_MID && r_last) begin
                        n_mode  = MODE_END;
                        n_state = S_CALC;
                    end else if (r_mode == MODE_MID) begin
                        o_cmd.win_from_cur = 1'b1;
                        n_held             = 2'd2;
                        n_state            = S_IDLE;
                    end else begin
                        n_held  = 2'd0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_MID;
            r_held  <= 2'd0;
            r_last  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_held  <= n_held;
            r_last  <= n_last;
            r_cnt   <= n_cnt;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("output loaded while a beat is still pending");
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held != 2'd3)
        else $error("column count out of range");
    a_first_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_held == 2'd0 && !i_last_column) |=> (r_state == S_IDLE && r_held == 2'd1))
        else $error("first column not simply held");
    a_single_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC && r_mode == MODE_ONE) |-> (r_held == 2'd0))
        else $error("single column pass with columns held");
`endif

endmodule

// ----- rtl/gb3_datapath.sv -----
// Datapath of the gaborish row filter: config registers, column window,
// four-stage multiply-accumulate pipeline, round/saturate and output register.
// Depends on gb3_pkg; commanded by gb3_ctrl.
module gb3_datapath import gb3_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [IDX_BITS-1:0]           i_cfg_index,
    input  logic [CFG_BITS-1:0]           i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] i_top_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_center_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_bottom_sample,
    input  t_dp_cmd                       i_cmd,
    output t_dp_status                    o_status,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_filtered_sample,
    output logic                          o_row_end
);

    logic [WEIGHT_BITS-1:0] r_side_w;
    logic [WEIGHT_BITS-1:0] r_diag_w;
    logic [GAIN_BITS-1:0]   r_gain;

    t_column w_in_col;
    t_column r_cur, r_prev, r_old;
    t_column w_left, w_mid;

    logic signed [SUM_BITS-1:0]    r_side_sum, r_diag_sum;
    logic signed [SAMPLE_BITS-1:0] r_c1, r_c2;
    logic signed [PROD_BITS-1:0]   r_p_side, r_p_diag;
    logic signed [ACC_BITS-1:0]    r_acc;
    logic signed [HG_BITS-1:0]     r_hg;
    logic [LG_BITS-1:0]            r_lg;
    logic signed [RND_BITS-1:0]    w_round;
    logic signed [Y_BITS-1:0]      w_y;
    logic                          w_ovf;
    logic signed [SAMPLE_BITS-1:0] w_sat;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_data;
    logic                          r_out_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_w <= SIDE_WEIGHT_RST;
            r_diag_w <= DIAG_WEIGHT_RST;
            r_gain   <= NORM_GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SIDE_WEIGHT: r_side_w <= i_cfg_data[WEIGHT_BITS-1:0];
                REG_DIAG_WEIGHT: r_diag_w <= i_cfg_data[WEIGHT_BITS-1:0];
                REG_NORM_GAIN:   r_gain   <= i_cfg_data[GAIN_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_in_col.t = i_top_sample;
    assign w_in_col.c = i_center_sample;
    assign w_in_col.b = i_bottom_sample;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cur) begin
            r_cur <= w_in_col;
        end
        if (i_cmd.win_from_in) begin
            r_old  <= r_prev;
            r_prev <= w_in_col;
        end else if (i_cmd.win_from_cur) begin
            r_old  <= r_prev;
            r_prev <= r_cur;
        end
    end

    always_comb begin
        case (i_cmd.lsel)
            LSEL_OLD:  w_left = r_old;
            LSEL_PREV: w_left = r_prev;
            default:   w_left = r_cur;
        endcase
        w_mid = i_cmd.mid_cur ? r_cur : r_prev;
    end

    // operands stay stable while a pass runs, so the stages free-run
    always_ff @(posedge i_clk) begin
        r_side_sum <= SUM_BITS'(w_mid.t) + SUM_BITS'(w_left.c)
                    + SUM_BITS'(r_cur.c) + SUM_BITS'(w_mid.b);
        r_diag_sum <= SUM_BITS'(w_left.t) + SUM_BITS'(r_cur.t)
                    + SUM_BITS'(w_left.b) + SUM_BITS'(r_cur.b);
        r_c1       <= w_mid.c;

        r_p_side   <= r_side_sum * $signed({1'b0, r_side_w});
        r_p_diag   <= r_diag_sum * $signed({1'b0, r_diag_w});
        r_c2       <= r_c1;

        r_acc      <= (ACC_BITS'(r_c2) <<< 16) + ACC_BITS'(r_p_side) + ACC_BITS'(r_p_diag);

        r_hg       <= $signed(r_acc[ACC_BITS-1:16]) * $signed({1'b0, r_gain});
        r_lg       <= r_acc[15:0] * r_gain;
    end

    // round half up, then clamp to the sample range
    assign w_round = RND_BITS'(r_hg) + RND_BITS'($signed({1'b0, r_lg[LG_BITS-1:16]}))
                   + RND_BITS'(32'sd32768);
    assign w_y     = w_round[RND_BITS-1:16];
    assign w_ovf   = (w_y[Y_BITS-1:SAMPLE_BITS-1] != {(Y_BITS-SAMPLE_BITS+1){w_y[Y_BITS-1]}});
    assign w_sat   = w_ovf ? {w_y[Y_BITS-1], {(SAMPLE_BITS-1){~w_y[Y_BITS-1]}}}
                           : w_y[SAMPLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= w_sat;
            r_out_end  <= i_cmd.out_end;
        end
    end

    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_filtered_sample  = r_out_data;
    assign o_row_end          = r_out_end;

endmodule

// ----- rtl/gaborish_3x3_row_filter.sv -----
// Top level of the gaborish 3x3 row filter: sequencer plus datapath.
// Depends on gb3_pkg, gb3_ctrl and gb3_datapath.
//
// One column beat in (top, center, bottom, last flag), filtered samples out one
// column behind; the last column of a longer row yields two beats, the second with
// row_end set, and a single-column row yields one beat with row_end set. Each
// result is one run of the shared four-stage multiply-accumulate pipeline,
// then an output load that waits for room. No beat is taken during a run or
// that wait. A beat is accepted while the previous result still waits in the
// output register. Weights and gain are to be written through the plain write
// port only while the block is idle; the user is bound by this, and the block
// itself does not enforce it.
module gaborish_3x3_row_filter import gb3_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_top_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_center_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_bottom_sample,
    input  logic                          i_last_column,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_filtered_sample,
    output logic                          o_row_end,
    input  logic                          i_cfg_we,
    input  logic [IDX_BITS-1:0]           i_cfg_index,
    input  logic [CFG_BITS-1:0]           i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    gb3_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_last_column (i_last_column),
        .o_in_ready    (o_in_ready),
        .i_status      (w_status),
        .o_cmd         (w_cmd)
    );

    gb3_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_top_sample      (i_top_sample),
        .i_center_sample   (i_center_sample),
        .i_bottom_sample   (i_bottom_sample),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_filtered_sample (o_filtered_sample),
        .o_row_end         (o_row_end)
    );

endmodule

// ----- tb/gaborish_3x3_row_filter_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of gaborish_3x3_row_filter: directed table, then random rows
// checked against an in-bench model of the filter. Depends on gb3_pkg and the block.
module gaborish_3x3_row_filter_tb;
    import gb3_pkg::*;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample value;
        logic    row_end;
    } t_pixel_out;

    typedef struct {
        bit                    is_cfg;
        logic [IDX_BITS-1:0]   idx;
        logic [CFG_BITS-1:0]   data;
        t_column               col;
        logic                  last;
        bit                    known;
        t_sample               want0;
        t_sample               want1;
    } t_row;

    localparam logic [IDX_BITS-1:0] REG_UNUSED = 2'd3;
    localparam t_sample S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam t_sample S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS-1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam int SETTLE_CYCLES = 16;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    t_sample                 i_top_sample = '0;
    t_sample                 i_center_sample = '0;
    t_sample                 i_bottom_sample = '0;
    logic                    i_last_column = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    t_sample                 o_filtered_sample;
    logic                    o_row_end;
    logic                    i_cfg_we = 1'b0;
    logic [IDX_BITS-1:0]     i_cfg_index = '0;
    logic [CFG_BITS-1:0]     i_cfg_data = '0;

    gaborish_3x3_row_filter DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_top_sample      (i_top_sample),
        .i_center_sample   (i_center_sample),
        .i_bottom_sample   (i_bottom_sample),
        .i_last_column     (i_last_column),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_filtered_sample (o_filtered_sample),
        .o_row_end         (o_row_end),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // model state
    logic [WEIGHT_BITS-1:0] side_w = SIDE_WEIGHT_RST;
    logic [WEIGHT_BITS-1:0] diag_w = DIAG_WEIGHT_RST;
    logic [GAIN_BITS-1:0]   gain   = NORM_GAIN_RST;
    t_column                win_old = '0;
    t_column                win_prev = '0;
    logic [1:0]             held = 2'd0;

    t_pixel_out pending_pixels[$];
    int         mismatches = 0;
    bit         calm = 1'b0;
    t_row       directed[$];

    function automatic t_sample gabor_pixel(t_column l, t_column m, t_column r);
        longint edge_sum, corner_sum, acc, hi, lo, s, y;
        edge_sum   = longint'(m.t) + longint'(l.c) + longint'(r.c) + longint'(m.b);
        corner_sum = longint'(l.t) + longint'(r.t) + longint'(l.b) + longint'(r.b);
        acc = longint'(m.c) * 65536 + edge_sum * longint'(side_w)
            + corner_sum * longint'(diag_w);
        hi = acc >>> 16;
        lo = acc - hi * 65536;
        s  = hi * longint'(gain) + ((lo * longint'(gain)) >>> 16);
        y  = (s + 32768) >>> 16;
        if (y > SAMPLE_MAX) begin
            y = SAMPLE_MAX;
        end else if (y < SAMPLE_MIN) begin
            y = SAMPLE_MIN;
        end
        return y[SAMPLE_BITS-1:0];
    endfunction

    // advance the column window by one beat; returns the number of results
    function automatic int filter_step(t_column cur, logic last, output t_pixel_out res[2]);
        if (held == 2'd0) begin
            if (last) begin
                res[0] = '{gabor_pixel(cur, cur, cur), 1'b1};
                return 1;
            end
            win_prev = cur;
            held = 2'd1;
            return 0;
        end
        res[0] = '{gabor_pixel((held == 2'd1) ? win_prev : win_old, win_prev, cur), 1'b0};
        if (last) begin
            res[1] = '{gabor_pixel(win_prev, cur, cur), 1'b1};
            held = 2'd0;
            return 2;
        end
        win_old = win_prev;
        win_prev = cur;
        held = 2'd2;
        return 1;
    endfunction

    function automatic logic [GAIN_BITS-1:0] matched_gain(logic [15:0] s, logic [15:0] d);
        longint den;
        den = 65536 + 4 * (longint'(s) + longint'(d));
        return GAIN_BITS'((longint'(1) <<< 32) / den);
    endfunction

    function automatic t_sample rand_sample();
        case ($urandom_range(0, 7))
            0: return S_MIN;
            1: return S_MAX;
            2: return t_sample'(int'($urandom_range(0, 8191)) - 4096);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic t_column rand_column();
        t_column c;
        c.t = rand_sample();
        c.c = rand_sample();
        c.b = rand_sample();
        return c;
    endfunction

    function automatic t_row reg_write(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
        t_row r;
        r = '{is_cfg: 1'b1, idx: idx, data: data, col: '0, last: 1'b0, known: 1'b0,
              want0: '0, want1: '0};
        return r;
    endfunction

    function automatic t_row col_beat(t_sample t, t_sample c, t_sample b, logic last);
        t_row r;
        r = '{is_cfg: 1'b0, idx: '0, data: '0, col: '{t, c, b}, last: last, known: 1'b0,
              want0: '0, want1: '0};
        return r;
    endfunction

    function automatic t_row col_known(t_sample t, t_sample c, t_sample b, logic last,
                                       t_sample w0, t_sample w1);
        t_row r;
        r = col_beat(t, c, b, last);
        r.known = 1'b1;
        r.want0 = w0;
        r.want1 = w1;
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic apply_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_SIDE_WEIGHT: side_w = data[WEIGHT_BITS-1:0];
            REG_DIAG_WEIGHT: diag_w = data[WEIGHT_BITS-1:0];
            REG_NORM_GAIN:   gain   = data[GAIN_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic send_beat(t_column cur, logic last, bit known = 1'b0,
                             t_sample want0 = '0, t_sample want1 = '0);
        t_pixel_out res[2];
        int         n;
        while (!calm && $urandom_range(0, 99) < 28) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_top_sample    <= cur.t;
        i_center_sample <= cur.c;
        i_bottom_sample <= cur.b;
        i_last_column   <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n = filter_step(cur, last, res);
        for (int k = 0; k < n; k++) begin
            if (known) begin
                res[k].value = (k == 0) ? want0 : want1;
            end
            pending_pixels.push_back(res[k]);
        end
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= 28);
    end

    always @(posedge i_clk) begin : check_output
        t_pixel_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pixels.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected beat, expected none, actual sample %0d row_end %0b",
                         $time, o_filtered_sample, o_row_end);
            end else begin
                want = pending_pixels.pop_front();
                if (o_filtered_sample !== want.value) begin
                    mismatches++;
                    $display("%0t: filtered_sample expected %0d actual %0d",
                             $time, want.value, o_filtered_sample);
                end
                if (o_row_end !== want.row_end) begin
                    mismatches++;
                    $display("%0t: row_end expected %0b actual %0b",
                             $time, want.row_end, o_row_end);
                end
            end
        end
    end

    initial begin
        int                     sent, len, guard;
        logic [WEIGHT_BITS-1:0] sw, dw;
        logic [GAIN_BITS-1:0]   g;

        // reset defaults: single-column rows, then a short row
        directed.push_back(col_known('0, '0, '0, 1'b1, '0, '0));
        directed.push_back(col_known(S_MAX, S_MAX, S_MAX, 1'b1, S_MAX, '0));
        directed.push_back(col_known(S_MIN, S_MIN, S_MIN, 1'b1, S_MIN, '0));
        directed.push_back(col_beat(100, 200, -300, 1'b0));
        directed.push_back(col_beat(S_MIN, S_MAX, S_MIN, 1'b0));
        directed.push_back(col_beat(S_MAX, S_MIN, S_MAX, 1'b1));
        // zero weights, unit gain: output is the center sample
        directed.push_back(reg_write(REG_SIDE_WEIGHT, '0));
        directed.push_back(reg_write(REG_DIAG_WEIGHT, '0));
        directed.push_back(reg_write(REG_NORM_GAIN, 17'd65536));
        directed.push_back(col_known(S_MAX, 12345, S_MIN, 1'b0, '0, '0));
        directed.push_back(col_known(S_MIN, -54321, S_MAX, 1'b1, 12345, -54321));
        directed.push_back(col_known('0, S_MIN, '0, 1'b1, S_MIN, '0));
        directed.push_back(col_known(S_MIN, S_MAX, S_MIN, 1'b1, S_MAX, '0));
        // full weights, gain above unity: saturates
        directed.push_back(reg_write(REG_SIDE_WEIGHT, 17'h0FFFF));
        directed.push_back(reg_write(REG_DIAG_WEIGHT, 17'h0FFFF));
        directed.push_back(reg_write(REG_NORM_GAIN, 17'h1FFFF));
        directed.push_back(col_known(S_MAX, S_MAX, S_MAX, 1'b1, S_MAX, '0));
        directed.push_back(col_known(S_MIN, S_MIN, S_MIN, 1'b1, S_MIN, '0));
        // zero gain
        directed.push_back(reg_write(REG_NORM_GAIN, '0));
        directed.push_back(col_known(S_MAX, S_MIN, S_MAX, 1'b0, '0, '0));
        directed.push_back(col_known(S_MIN, S_MAX, S_MIN, 1'b0, '0, '0));
        directed.push_back(col_known(123, -456, 789, 1'b1, '0, '0));
        // out-of-range index must not touch the gain
        directed.push_back(reg_write(REG_UNUSED, 17'h1FFFF));
        directed.push_back(col_known(S_MAX, S_MAX, S_MAX, 1'b1, '0, '0));
        directed.push_back(reg_write(REG_NORM_GAIN, 17'd40000));
        directed.push_back(col_beat(-1, 1, -1, 1'b0));
        directed.push_back(col_beat(S_MAX, -1, '0, 1'b0));
        directed.push_back(col_beat(-2048, 2047, 4095, 1'b1));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].is_cfg) begin
                apply_reg(directed[i].idx, directed[i].data);
            end else begin
                send_beat(directed[i].col, directed[i].last, directed[i].known,
                          directed[i].want0, directed[i].want1);
            end
        end

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    sw = SIDE_WEIGHT_RST;
                    dw = DIAG_WEIGHT_RST;
                    g  = NORM_GAIN_RST;
                end
                1: begin
                    sw = WEIGHT_BITS'($urandom_range(0, 16383));
                    dw = WEIGHT_BITS'($urandom_range(0, 16383));
                    g  = matched_gain(sw, dw);
                end
                2: begin
                    sw = WEIGHT_BITS'($urandom);
                    dw = WEIGHT_BITS'($urandom);
                    g  = matched_gain(sw, dw);
                end
                3: begin
                    sw = '1;
                    dw = '1;
                    g  = GAIN_BITS'($urandom_range(0, 131071));
                end
                default: begin
                    sw = WEIGHT_BITS'($urandom);
                    dw = WEIGHT_BITS'($urandom);
                    g  = GAIN_BITS'($urandom_range(0, 131071));
                end
            endcase
            apply_reg(REG_SIDE_WEIGHT, CFG_BITS'(sw));
            apply_reg(REG_DIAG_WEIGHT, CFG_BITS'(dw));
            apply_reg(REG_NORM_GAIN, g);
            calm <= (phase == 2);
            sent = 0;
            while (sent < 100) begin
                if ($urandom_range(0, 19) == 0) begin
                    len = $urandom_range(20, 40);
                end else if ($urandom_range(0, 3) == 0) begin
                    len = 1;
                end else begin
                    len = $urandom_range(2, 12);
                end
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 79) == 0) begin
                        i_in_valid <= 1'b0;
                        wait_drained();
                        @(posedge i_clk);
                    end
                    send_beat(rand_column(), k == len - 1);
                    sent++;
                end
            end
        end

        i_in_valid <= 1'b0;
        calm <= 1'b0;
        for (guard = 0; guard < 5000 && pending_pixels.size() != 0; guard++) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (pending_pixels.size() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, pending_pixels.size());
            mismatches += pending_pixels.size();
        end
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
